/* src/cfr_pkg.sv */
// Package for the counter frame receiver.
// Holds frame phase codes, register indexes, reset values and the result and config record types.
// No dependencies.
package cfr_pkg;

    localparam int unsigned PHASE_W = 4;

    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_SYNC    = 4'd0;
    localparam phase_t PH_CMD_HI  = 4'd1;
    localparam phase_t PH_CMD_LO  = 4'd2;
    localparam phase_t PH_GAIN    = 4'd3;
    localparam phase_t PH_A_HI    = 4'd4;
    localparam phase_t PH_A_LO    = 4'd5;
    localparam phase_t PH_B_HI    = 4'd6;
    localparam phase_t PH_B_LO    = 4'd7;
    localparam phase_t PH_C_HI    = 4'd8;
    localparam phase_t PH_C_LO    = 4'd9;
    localparam phase_t PH_D_HI    = 4'd10;
    localparam phase_t PH_D_LO    = 4'd11;
    localparam phase_t PH_CHECK   = 4'd12;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_COMMAND = 1'd1;

    localparam logic [7:0]  SYNC_BYTE_RESET      = 8'hE7;
    localparam logic [15:0] ACCEPT_COMMAND_RESET = 16'h0002;

    typedef struct packed {
        logic [7:0]  gain;
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] count_c;
        logic [15:0] count_d;
    } result_t;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [15:0] accept_command;
    } cfg_t;

endpackage

/* src/counter_frame_receiver.sv */
// Counter frame receiver: one received byte per item, one result per good frame.
// Latency: a result is valid the cycle after its check byte is accepted.
// Throughput: one byte per cycle; the only stall is a check byte arriving
// while the previous result is still held in the output register.
// Reset: synchronous, active low; returns to sync hunt, registers to 0xE7 / 0x0002.
// Depends on cfr_pkg, cfr_cfg_regs and cfr_frame_parser.
module counter_frame_receiver
    import cfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_gain,
    output logic [15:0]           m_count_a,
    output logic [15:0]           m_count_b,
    output logic [15:0]           m_count_c,
    output logic [15:0]           m_count_d
);

    cfg_t    cfg;
    logic    byte_en;
    logic    at_check;
    logic    result_en;
    result_t result;

    logic    m_valid_reg;
    result_t out_reg;

    cfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // only the check byte can produce a result, so only it waits on the output
    assign s_ready = !at_check || !m_valid_reg || m_ready;
    assign byte_en = s_valid && s_ready;

    cfr_frame_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .byte_en   (byte_en),
        .rx_byte   (s_rx_byte),
        .at_check  (at_check),
        .result_en (result_en),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_en) begin
            out_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_gain    = out_reg.gain;
    assign m_count_a = out_reg.count_a;
    assign m_count_b = out_reg.count_b;
    assign m_count_c = out_reg.count_c;
    assign m_count_d = out_reg.count_d;

endmodule

/* src/cfr_cfg_regs.sv */
// Configuration registers of the counter frame receiver.
// Depends on cfr_pkg (register indexes, reset values, cfg_t).
module cfr_cfg_regs
    import cfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte      <= SYNC_BYTE_RESET;
            cfg_reg.accept_command <= ACCEPT_COMMAND_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SYNC_BYTE:      cfg_reg.sync_byte      <= cfg_wdata[7:0];
                REG_ACCEPT_COMMAND: cfg_reg.accept_command <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/cfr_frame_parser.sv */
// Frame parser: sync hunt, field assembly and check of one frame per pass.
// Depends on cfr_pkg (phase codes, cfg_t, result_t).
module cfr_frame_parser
    import cfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output logic       at_check,
    output logic       result_en,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] cmd_reg;
    logic [7:0]  gain_reg;
    logic [15:0] val_a_reg, val_b_reg, val_c_reg, val_d_reg;
    logic [15:0] xsum;

    always_comb begin
        case (phase_reg)
            PH_CMD_HI: phase_next = PH_CMD_LO;
            PH_CMD_LO: phase_next = PH_GAIN;
            PH_GAIN:   phase_next = PH_A_HI;
            PH_A_HI:   phase_next = PH_A_LO;
            PH_A_LO:   phase_next = PH_B_HI;
            PH_B_HI:   phase_next = PH_B_LO;
            PH_B_LO:   phase_next = PH_C_HI;
            PH_C_HI:   phase_next = PH_C_LO;
            PH_C_LO:   phase_next = PH_D_HI;
            PH_D_HI:   phase_next = PH_D_LO;
            PH_D_LO:   phase_next = PH_CHECK;
            PH_CHECK:  phase_next = PH_SYNC;
            // sync hunt; unused codes fall here too
            default:   phase_next = (rx_byte == cfg.sync_byte) ? PH_CMD_HI : PH_SYNC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
        end else if (byte_en) begin
            phase_reg <= phase_next;
        end
    end

    // high byte write clears the low byte, as a fresh word
    always_ff @(posedge aclk) begin
        if (byte_en) begin
            case (phase_reg)
                PH_CMD_HI: cmd_reg   <= {rx_byte, 8'h00};
                PH_CMD_LO: cmd_reg   <= {cmd_reg[15:8], rx_byte};
                PH_GAIN:   gain_reg  <= rx_byte;
                PH_A_HI:   val_a_reg <= {rx_byte, 8'h00};
                PH_A_LO:   val_a_reg <= {val_a_reg[15:8], rx_byte};
                PH_B_HI:   val_b_reg <= {rx_byte, 8'h00};
                PH_B_LO:   val_b_reg <= {val_b_reg[15:8], rx_byte};
                PH_C_HI:   val_c_reg <= {rx_byte, 8'h00};
                PH_C_LO:   val_c_reg <= {val_c_reg[15:8], rx_byte};
                PH_D_HI:   val_d_reg <= {rx_byte, 8'h00};
                PH_D_LO:   val_d_reg <= {val_d_reg[15:8], rx_byte};
                default: ;
            endcase
        end
    end

    assign xsum     = cmd_reg ^ val_a_reg ^ val_b_reg ^ val_c_reg ^ val_d_reg;
    assign at_check = (phase_reg == PH_CHECK);

    assign result_en = byte_en && at_check
                       && (xsum == {8'h00, rx_byte})
                       && (cmd_reg == cfg.accept_command);

    assign result.gain    = gain_reg;
    assign result.count_a = val_a_reg;
    assign result.count_b = val_b_reg;
    assign result.count_c = val_c_reg;
    assign result.count_d = val_d_reg;

endmodule
